// ===== rtl/msr_pkg.sv =====
// ----------------------------------------------------------------------------
// msr_pkg: shared types and constants for the subset route search
// Field widths, command codes, register indexes and the structs that pass
// between the top level and the search sequencer.
// ----------------------------------------------------------------------------
package msr_pkg;

	// node numbers, counts and slot values all fit in one nibble
	localparam int NODE_W = 4;
	// loop counter, can hold k + 1
	localparam int CNT_W = 5;
	// running best never exceeds the no-route value
	localparam int BEST_W = 14;
	localparam int HOP_W = 16;
	localparam int RES_W = 16;
	localparam int IN_TDATA_W = 40;
	localparam int OUT_TDATA_W = 16;
	localparam int CFG_W = 4;
	localparam int DIST_DEPTH = 1 << (2 * NODE_W);

	localparam logic [BEST_W-1:0] NO_ROUTE = 14'd9999;

	// command codes
	localparam logic [1:0] OP_WR_DIST  = 2'd0;
	localparam logic [1:0] OP_WR_ROUTE = 2'd1;
	localparam logic [1:0] OP_RUN      = 2'd2;

	// register indexes
	localparam logic [0:0] REG_PLANET_COUNT = 1'b0;
	localparam logic [0:0] REG_CHOSEN_COUNT = 1'b1;

	// run request towards the sequencer
	typedef struct packed {
		logic              go;
		logic [NODE_W-1:0] n;
		logic [NODE_W-1:0] k;
		logic [NODE_W-1:0] end_node;
	} run_cmd_t;

	// sequencer status towards the top level
	typedef struct packed {
		logic              idle;
		logic              res_valid;
		logic [BEST_W-1:0] best;
	} run_stat_t;

	// read addresses into the route and distance memories
	typedef struct packed {
		logic [NODE_W-1:0]   route_slot;
		logic [2*NODE_W-1:0] dist_addr;
	} lookup_t;

endpackage

// ===== rtl/msr_ram.sv =====
// ----------------------------------------------------------------------------
// msr_ram: generic single-port-write, single-port-read memory
// One write and one registered read per cycle, no reset on the contents.
// ----------------------------------------------------------------------------
module msr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/msr_seq.sv =====
// ----------------------------------------------------------------------------
// msr_seq: combination sequencer and bottleneck walk
// Holds the chosen slot list in a memory, walks each combination through a
// three-stage read pipeline (slot, route, distance) and steps to the next
// combination by scanning the slot list from the back.
// ----------------------------------------------------------------------------
module msr_seq #(
	parameter int MAX_PLANETS = 14,
	parameter int DIST_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  msr_pkg::run_cmd_t             cmd,
	input  logic                          res_free,
	output msr_pkg::run_stat_t            stat,
	output msr_pkg::lookup_t              lookup,
	input  logic [msr_pkg::NODE_W-1:0]    route_rdata,
	input  logic [DIST_WIDTH-1:0]         dist_rdata
);

	localparam int SW = (MAX_PLANETS > 1) ? $clog2(MAX_PLANETS) : 1;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_FILL    = 3'd1;
	localparam logic [2:0] ST_WALK    = 3'd2;
	localparam logic [2:0] ST_ADV_RD  = 3'd3;
	localparam logic [2:0] ST_ADV_CHK = 3'd4;
	localparam logic [2:0] ST_EMIT    = 3'd5;

	logic [2:0]                      state_q;
	logic [msr_pkg::NODE_W-1:0]      n_q;
	logic [msr_pkg::NODE_W-1:0]      k_q;
	logic [msr_pkg::NODE_W-1:0]      end_q;
	logic [msr_pkg::NODE_W-1:0]      pos_q;
	logic [msr_pkg::CNT_W-1:0]       idx_q;
	logic [msr_pkg::CNT_W-1:0]       fill_q;
	logic [DIST_WIDTH-1:0]           worst_q;
	logic [msr_pkg::BEST_W-1:0]      best_q;
	logic                            v_s1;
	logic                            v_s2;
	logic                            v_s3;
	logic                            last_s1;
	logic                            last_s2;
	logic                            last_s3;

	logic                            ch_we;
	logic [SW-1:0]                   ch_addr;
	logic [msr_pkg::NODE_W-1:0]      ch_wdata;
	logic [msr_pkg::NODE_W-1:0]      ch_rdata;
	logic [msr_pkg::CNT_W-1:0]       k_ext;
	logic [msr_pkg::CNT_W-1:0]       limit;
	logic                            issue;
	logic                            found;
	logic [msr_pkg::NODE_W-1:0]      planet;
	logic [DIST_WIDTH-1:0]           hop;
	logic                            hop_better;

	// chosen slot list
	msr_ram #(
		.WIDTH(msr_pkg::NODE_W),
		.DEPTH(MAX_PLANETS)
	) u_chosen_ram (
		.clk  (clk),
		.we   (ch_we),
		.waddr(ch_addr),
		.wdata(ch_wdata),
		.raddr(ch_addr),
		.rdata(ch_rdata)
	);

	// slot list control and walk datapath
	always_comb begin
		k_ext    = msr_pkg::CNT_W'(k_q);
		ch_addr  = SW'(idx_q);
		issue    = (state_q == ST_WALK) && (idx_q <= k_ext);
		limit    = msr_pkg::CNT_W'(n_q) - k_ext + idx_q;
		found    = msr_pkg::CNT_W'(ch_rdata) < limit;
		ch_we    = ((state_q == ST_FILL) && (idx_q != k_ext)) ||
			((state_q == ST_ADV_CHK) && found);
		ch_wdata = (state_q == ST_ADV_CHK) ? (ch_rdata + msr_pkg::NODE_W'(1)) :
			fill_q[msr_pkg::NODE_W-1:0];
		// the closing hop of each combination goes to the end node
		planet            = last_s2 ? end_q : route_rdata;
		lookup.route_slot = ch_rdata;
		lookup.dist_addr  = {pos_q, planet};
		hop               = (dist_rdata > worst_q) ? dist_rdata : worst_q;
		hop_better        = hop < DIST_WIDTH'(best_q);
		stat.idle         = (state_q == ST_IDLE);
		stat.res_valid    = (state_q == ST_EMIT) && res_free;
		stat.best         = best_q;
	end

	// sequencer state, loop counter and pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.go) begin
						idx_q   <= '0;
						state_q <= (cmd.k > cmd.n) ? ST_EMIT : ST_FILL;
					end
				end
				ST_FILL: begin
					if (idx_q == k_ext) begin
						idx_q   <= '0;
						state_q <= ST_WALK;
					end else begin
						idx_q <= idx_q + msr_pkg::CNT_W'(1);
					end
				end
				ST_WALK: begin
					if (issue) begin
						idx_q <= idx_q + msr_pkg::CNT_W'(1);
					end
					if (v_s3 && last_s3) begin
						if (k_q == '0) begin
							state_q <= ST_EMIT;
						end else begin
							idx_q   <= k_ext - msr_pkg::CNT_W'(1);
							state_q <= ST_ADV_RD;
						end
					end
				end
				ST_ADV_RD: begin
					state_q <= ST_ADV_CHK;
				end
				ST_ADV_CHK: begin
					if (found) begin
						idx_q   <= idx_q + msr_pkg::CNT_W'(1);
						state_q <= ST_FILL;
					end else if (idx_q == '0) begin
						state_q <= ST_EMIT;
					end else begin
						idx_q   <= idx_q - msr_pkg::CNT_W'(1);
						state_q <= ST_ADV_RD;
					end
				end
				ST_EMIT: begin
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// run parameters, walk position and running maxima
	always_ff @(posedge clk) begin
		last_s1 <= (idx_q == k_ext);
		last_s2 <= last_s1;
		last_s3 <= last_s2;
		if ((state_q == ST_IDLE) && cmd.go) begin
			n_q     <= cmd.n;
			k_q     <= cmd.k;
			end_q   <= cmd.end_node;
			best_q  <= msr_pkg::NO_ROUTE;
			worst_q <= '0;
			pos_q   <= '0;
			fill_q  <= '0;
		end
		// refill value after the scan bumps one slot
		if ((state_q == ST_ADV_CHK) && found) begin
			fill_q <= msr_pkg::CNT_W'(ch_rdata) + msr_pkg::CNT_W'(2);
		end else if ((state_q == ST_FILL) && (idx_q != k_ext)) begin
			fill_q <= fill_q + msr_pkg::CNT_W'(1);
		end
		// each combination starts again from the start node
		if (v_s2) begin
			pos_q <= last_s2 ? '0 : planet;
		end
		if (v_s3) begin
			if (last_s3) begin
				worst_q <= '0;
				if (hop_better) begin
					best_q <= hop[msr_pkg::BEST_W-1:0];
				end
			end else begin
				worst_q <= hop;
			end
		end
	end

	// walk tokens only live while walking
	a_tok_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 || v_s2 || v_s3) |-> (state_q == ST_WALK))
		else $error("walk token outside walk state");

	// running best never rises above the no-route value during a run
	a_best_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (best_q <= msr_pkg::NO_ROUTE))
		else $error("running best above no-route value");

	// slot scan stays inside the chosen list
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADV_CHK) |-> (idx_q < k_ext))
		else $error("slot scan index out of range");

	// refill never runs past k
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL) |-> (idx_q <= k_ext))
		else $error("slot refill index out of range");

endmodule

// ===== rtl/min_bottleneck_subset_route.sv =====
// ----------------------------------------------------------------------------
// min_bottleneck_subset_route: minimum bottleneck over route subsets
// Loads a distance table and a route list, then on a run command finds the
// smallest largest hop over all choices of k route slots.
//
//  channel | handshake          | content
//  --------+--------------------+-----------------------------------------
//  s_*     | s_tvalid/s_tready  | command: table write, route write, run
//  m_*     | m_tvalid/m_tready  | best bottleneck of a run
//  cfg_*   | cfg_wr_en          | planet count (0), chosen count (1)
//
// a run walks each combination hop by hop (one distance read per hop through three read
// stages) and then steps to the next combination by moving slots
// no clearing pass after reset: both tables are undefined until written
// input is held off while a run is in progress; the result waits in the
// output register, and the next command is taken meanwhile
// ----------------------------------------------------------------------------
module min_bottleneck_subset_route #(
	parameter int MAX_PLANETS = 14,
	parameter int DIST_WIDTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// opcode, from_node, to_node, hop_distance, route_slot, route_planet
	input  logic [msr_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// best_bottleneck
	output logic [msr_pkg::OUT_TDATA_W-1:0]    m_tdata,
	input  logic                               cfg_wr_en,
	input  logic [0:0]                         cfg_index,
	input  logic [msr_pkg::CFG_W-1:0]          cfg_wdata
);

	localparam int SW = (MAX_PLANETS > 1) ? $clog2(MAX_PLANETS) : 1;

	logic [1:0]                        opcode;
	logic [msr_pkg::NODE_W-1:0]        from_node;
	logic [msr_pkg::NODE_W-1:0]        to_node;
	logic [msr_pkg::HOP_W-1:0]         hop_distance;
	logic [msr_pkg::NODE_W-1:0]        route_slot;
	logic [msr_pkg::NODE_W-1:0]        route_planet;
	logic                              in_acc;
	logic                              dist_we;
	logic                              route_we;
	logic                              run_go;
	logic [msr_pkg::NODE_W-1:0]        n_sat;
	logic [msr_pkg::CFG_W-1:0]         planet_count_q;
	logic [msr_pkg::CFG_W-1:0]         chosen_count_q;
	logic                              m_tvalid_q;
	logic [msr_pkg::OUT_TDATA_W-1:0]   m_tdata_q;
	logic                              res_free;
	logic [msr_pkg::NODE_W-1:0]        route_rdata;
	logic [DIST_WIDTH-1:0]             dist_rdata;
	msr_pkg::run_cmd_t                 cmd;
	msr_pkg::run_stat_t                stat;
	msr_pkg::lookup_t                  lookup;

	// input field unpacking
	assign opcode       = s_tdata[1:0];
	assign from_node    = s_tdata[5:2];
	assign to_node      = s_tdata[9:6];
	assign hop_distance = s_tdata[25:10];
	assign route_slot   = s_tdata[29:26];
	assign route_planet = s_tdata[33:30];

	assign s_tready = stat.idle;
	assign in_acc   = s_tvalid && s_tready;

	// command decode
	always_comb begin
		dist_we  = 1'b0;
		route_we = 1'b0;
		run_go   = 1'b0;
		unique case (opcode)
			msr_pkg::OP_WR_DIST:  dist_we  = in_acc;
			msr_pkg::OP_WR_ROUTE: route_we = in_acc && (32'(route_slot) < MAX_PLANETS);
			msr_pkg::OP_RUN:      run_go   = in_acc;
			default: begin
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			planet_count_q <= msr_pkg::CFG_W'(14);
			chosen_count_q <= msr_pkg::CFG_W'(1);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				msr_pkg::REG_PLANET_COUNT: planet_count_q <= cfg_wdata;
				msr_pkg::REG_CHOSEN_COUNT: chosen_count_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// run request, planet count saturated to the route length
	always_comb begin
		n_sat = (32'(planet_count_q) > MAX_PLANETS) ? msr_pkg::NODE_W'(MAX_PLANETS) :
			planet_count_q;
		cmd.go       = run_go;
		cmd.n        = n_sat;
		cmd.k        = chosen_count_q;
		cmd.end_node = n_sat + msr_pkg::NODE_W'(1);
	end

	// distance table, entry at from * 16 + to
	msr_ram #(
		.WIDTH(DIST_WIDTH),
		.DEPTH(msr_pkg::DIST_DEPTH)
	) u_dist_ram (
		.clk  (clk),
		.we   (dist_we),
		.waddr({from_node, to_node}),
		.wdata(DIST_WIDTH'(hop_distance)),
		.raddr(lookup.dist_addr),
		.rdata(dist_rdata)
	);

	// route list
	msr_ram #(
		.WIDTH(msr_pkg::NODE_W),
		.DEPTH(MAX_PLANETS)
	) u_route_ram (
		.clk  (clk),
		.we   (route_we),
		.waddr(SW'(route_slot)),
		.wdata(route_planet),
		.raddr(SW'(lookup.route_slot)),
		.rdata(route_rdata)
	);

	msr_seq #(
		.MAX_PLANETS(MAX_PLANETS),
		.DIST_WIDTH (DIST_WIDTH)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.res_free   (res_free),
		.stat       (stat),
		.lookup     (lookup),
		.route_rdata(route_rdata),
		.dist_rdata (dist_rdata)
	);

	// output register
	assign res_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (stat.res_valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.res_valid) begin
			m_tdata_q <= msr_pkg::OUT_TDATA_W'(stat.best);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ===== tb/sv/tb_min_bottleneck_subset_route.sv =====
// ----------------------------------------------------------------------------
// tb_min_bottleneck_subset_route: self-checking bench for the subset route
// Loads distance entries and route slots through the command stream, runs
// searches under a range of planet and pick counts, and checks every search
// result against a behavioural predictor held in a small scoreboard.
// The sender works in bursts with random gaps and the receiver stalls at
// random. Before each search every table entry the search may touch is written.
// ----------------------------------------------------------------------------
module tb_min_bottleneck_subset_route;

	localparam int PLANETS = 14;
	localparam int NODES = 16;
	localparam int RANDOM_ITEMS = 100;
	localparam int SETTLE_CYCLES = 20;
	localparam int CYCLE_LIMIT = 1500000;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// one command as it travels in s_tdata, opcode in the lowest bits
	typedef struct packed {
		logic [3:0]  route_planet;
		logic [3:0]  route_slot;
		logic [15:0] hop_distance;
		logic [3:0]  to_node;
		logic [3:0]  from_node;
		logic [1:0]  opcode;
	} search_cmd_t;

	localparam int CMD_W = $bits(search_cmd_t);

	// scoreboard: shadow tables, search predictor and pending results
	class route_search_board;
		logic [15:0] dist_tab [NODES*NODES];
		logic [3:0]  route [PLANETS];
		logic [3:0]  planet_reg;
		logic [3:0]  pick_reg;
		logic [15:0] best_q [$];
		int          errors;

		function new();
			foreach (dist_tab[i])
				dist_tab[i] = '0;
			foreach (route[i])
				route[i] = '0;
			planet_reg = 4'd14;
			pick_reg = 4'd1;
			errors = 0;
		endfunction

		function void set_reg(logic [0:0] idx, logic [3:0] val);
			if (idx == msr_pkg::REG_PLANET_COUNT)
				planet_reg = val;
			else
				pick_reg = val;
		endfunction

		// smallest largest hop over every choice of k slots in slot order
		function logic [15:0] min_bottleneck();
			int n, k, end_node, r, i, j, pos, planet, worst, best;
			int slots [PLANETS];
			bit more;
			n = (planet_reg > PLANETS) ? PLANETS : planet_reg;
			k = pick_reg;
			end_node = (n + 1) % NODES;
			best = int'(msr_pkg::NO_ROUTE);
			if (k > n)
				return 16'(best);
			for (i = 0; i < k; i++)
				slots[i] = i;
			do begin
				worst = 0;
				pos = 0;
				for (j = 0; j < k; j++) begin
					planet = route[slots[j]];
					if (dist_tab[pos*NODES + planet] > worst)
						worst = dist_tab[pos*NODES + planet];
					pos = planet;
				end
				if (dist_tab[pos*NODES + end_node] > worst)
					worst = dist_tab[pos*NODES + end_node];
				if (worst < best)
					best = worst;
				// step to the next choice in lexicographic order
				more = 1'b0;
				r = k;
				while (r > 0 && !more) begin
					r--;
					if (slots[r] < n - k + r)
						more = 1'b1;
				end
				if (more) begin
					slots[r]++;
					for (i = r + 1; i < k; i++)
						slots[i] = slots[i-1] + 1;
				end
			end while (more);
			return 16'(best);
		endfunction

		function void note_command(search_cmd_t c);
			case (c.opcode)
				msr_pkg::OP_WR_DIST: dist_tab[c.from_node*NODES + c.to_node] = c.hop_distance;
				msr_pkg::OP_WR_ROUTE: begin
					if (c.route_slot < PLANETS)
						route[c.route_slot] = c.route_planet;
				end
				msr_pkg::OP_RUN: best_q.push_back(min_bottleneck());
				default: ;
			endcase
		endfunction

		function void check_result(logic [15:0] got);
			logic [15:0] exp_best;
			if (best_q.size() == 0) begin
				$error("best_bottleneck: no result pending, actual %0d", got);
				errors++;
			end else begin
				exp_best = best_q.pop_front();
				if (got !== exp_best) begin
					$error("best_bottleneck: expected %0d, actual %0d", exp_best, got);
					errors++;
				end
			end
		endfunction

		function int pending();
			return best_q.size();
		endfunction
	endclass

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              s_tvalid = 1'b0;
	logic                              s_tready;
	// opcode, from_node, to_node, hop_distance, route_slot, route_planet
	logic [msr_pkg::IN_TDATA_W-1:0]    s_tdata = '0;
	logic                              m_tvalid;
	logic                              m_tready = 1'b0;
	// best_bottleneck
	logic [msr_pkg::OUT_TDATA_W-1:0]   m_tdata;
	logic                              cfg_wr_en = 1'b0;
	logic [0:0]                        cfg_index = '0;
	logic [msr_pkg::CFG_W-1:0]         cfg_wdata = '0;

	route_search_board board = new();

	// stimulus side bookkeeping of what has been written so far
	bit         dist_known [NODES*NODES];
	bit         route_known [PLANETS];
	logic [3:0] route_shadow [PLANETS];
	int         cur_n = 14;
	int         cur_k = 1;
	int         burst_left = 0;
	bit         quiet = 1'b0;
	int         stall_left = 0;
	int         cycle_count = 0;

	min_bottleneck_subset_route #(
		.MAX_PLANETS(PLANETS),
		.DIST_WIDTH(16)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// cycle counter and timeout
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("FAIL min_bottleneck_subset_route");
		$finish;
	end

	// receiver: random stall stretches, always ready in quiet phases
	always @(posedge clk) begin
		if (quiet) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 5) == 0)
				stall_left = $urandom_range(1, 40);
		end
	end

	// monitor both streams on each completed transaction
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			board.note_command(search_cmd_t'(s_tdata[CMD_W-1:0]));
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tdata);
	end

	function automatic search_cmd_t rand_cmd();
		search_cmd_t c;
		c = search_cmd_t'(CMD_W'({$urandom, $urandom}));
		return c;
	endfunction

	// hop values biased around the no-route value and towards small numbers
	function automatic logic [15:0] rand_hop();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 200));
			1: return 16'($urandom_range(0, 9998));
			2: return 16'($urandom_range(9990, 10010));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic int route_end();
		return (((cur_n > PLANETS) ? PLANETS : cur_n) + 1) % NODES;
	endfunction

	// node likely to lie on a searched path
	function automatic logic [3:0] path_node();
		case ($urandom_range(0, 3))
			0: return 4'd0;
			1: return 4'(route_end());
			default: return route_shadow[$urandom_range(0, PLANETS-1)];
		endcase
	endfunction

	// one input transaction, with a random gap before each new burst outside quiet phases
	task automatic send_cmd(search_cmd_t c);
		if (burst_left == 0) begin
			if (!quiet) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			burst_left = quiet ? 1000 : $urandom_range(1, 10);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(msr_pkg::IN_TDATA_W-CMD_W){1'b0}}, c};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		burst_left--;
	endtask

	task automatic write_dist(int from_n, int to_n, logic [15:0] hop);
		search_cmd_t c;
		c = rand_cmd();
		c.opcode = msr_pkg::OP_WR_DIST;
		c.from_node = 4'(from_n);
		c.to_node = 4'(to_n);
		c.hop_distance = hop;
		dist_known[from_n*NODES + to_n] = 1'b1;
		send_cmd(c);
	endtask

	task automatic write_route(int slot, logic [3:0] planet);
		search_cmd_t c;
		c = rand_cmd();
		c.opcode = msr_pkg::OP_WR_ROUTE;
		c.route_slot = 4'(slot);
		c.route_planet = planet;
		if (slot < PLANETS) begin
			route_known[slot] = 1'b1;
			route_shadow[slot] = planet;
		end
		send_cmd(c);
	endtask

	task automatic send_noise();
		search_cmd_t c;
		c = rand_cmd();
		c.opcode = OP_UNUSED;
		send_cmd(c);
	endtask

	// write every entry the search may read, then issue the run
	task automatic request_search();
		int n_eff, a, b;
		bit [NODES-1:0] on_path;
		search_cmd_t c;
		n_eff = (cur_n > PLANETS) ? PLANETS : cur_n;
		on_path = '0;
		if (cur_k <= n_eff) begin
			on_path[0] = 1'b1;
			on_path[route_end()] = 1'b1;
			if (cur_k > 0) begin
				for (a = 0; a < n_eff; a++) begin
					if (!route_known[a])
						write_route(a, 4'($urandom_range(0, 15)));
					on_path[route_shadow[a]] = 1'b1;
				end
			end
		end
		for (a = 0; a < NODES; a++)
			for (b = 0; b < NODES; b++)
				if (on_path[a] && on_path[b] && !dist_known[a*NODES + b])
					write_dist(a, b, rand_hop());
		c = rand_cmd();
		c.opcode = msr_pkg::OP_RUN;
		send_cmd(c);
	endtask

	// hold the sender until every pending result has come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(int n, int k);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_index <= msr_pkg::REG_PLANET_COUNT;
		cfg_wdata <= msr_pkg::CFG_W'(n);
		@(posedge clk);
		cfg_index <= msr_pkg::REG_CHOSEN_COUNT;
		cfg_wdata <= msr_pkg::CFG_W'(k);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		board.set_reg(msr_pkg::REG_PLANET_COUNT, 4'(n));
		board.set_reg(msr_pkg::REG_CHOSEN_COUNT, 4'(k));
		cur_n = n;
		cur_k = k;
	endtask

	// main sequence
	initial begin
		int n, k, i, count, pick, phase, rand_items;
		foreach (route_shadow[j])
			route_shadow[j] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: slot limits, ignored slots, unused opcode, extreme hops
		set_config(2, 1);
		write_route(0, 4'd4);
		write_route(1, 4'd15);
		write_route(13, 4'd2);
		write_route(14, 4'd6);
		write_route(15, 4'd9);
		send_noise();
		write_dist(0, 4, 16'd9999);
		write_dist(4, 3, 16'hFFFF);
		write_dist(0, 15, 16'd100);
		write_dist(15, 3, 16'd0);
		write_dist(15, 15, 16'hFFFF);
		write_dist(0, 0, 16'd0);
		request_search();
		// no picks: only the start to end hop
		set_config(2, 0);
		write_dist(0, 3, 16'd10000);
		request_search();
		// more picks than planets
		set_config(2, 3);
		request_search();
		// zero planets, end node is node 1
		set_config(0, 0);
		write_dist(0, 1, 16'd9998);
		request_search();
		set_config(14, 15);
		request_search();
		// planet count saturates at the table size
		set_config(15, 15);
		request_search();

		// random phases, the heavy settings first and kept short
		rand_items = 0;
		phase = 0;
		while (rand_items < RANDOM_ITEMS) begin
			case (phase)
				0: begin n = 14; k = 7; end
				1: begin n = 15; k = 3; end
				2: begin n = 14; k = 14; end
				3: begin n = 1; k = 15; end
				default: begin
					n = $urandom_range(0, 8);
					k = $urandom_range(0, n + 1);
				end
			endcase
			set_config(n, k);
			quiet = ($urandom_range(0, 3) == 0);
			count = (phase < 2) ? 4 : $urandom_range(6, 14);
			for (i = 0; i < count; i++) begin
				pick = $urandom_range(0, 19);
				if (pick < 5) begin
					request_search();
				end else if (pick < 10) begin
					if ($urandom_range(0, 3) == 0 || n == 0)
						write_route($urandom_range(0, 15), 4'($urandom));
					else
						write_route($urandom_range(0, ((n > PLANETS) ? PLANETS : n) - 1),
							4'($urandom));
				end else if (pick < 17) begin
					if ($urandom_range(0, 9) < 7)
						write_dist(path_node(), path_node(), rand_hop());
					else
						write_dist($urandom_range(0, 15), $urandom_range(0, 15), rand_hop());
				end else begin
					send_noise();
					rand_items--;
				end
				rand_items++;
			end
			request_search();
			rand_items++;
			phase++;
		end

		quiet = 1'b0;
		wait_drained();
		repeat (50) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("PASS min_bottleneck_subset_route");
		else
			$display("FAIL min_bottleneck_subset_route");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/msr_pkg.sv
rtl/msr_ram.sv
rtl/msr_seq.sv
rtl/min_bottleneck_subset_route.sv
tb/sv/tb_min_bottleneck_subset_route.sv
